// ===== rtl/dmf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmf_pkg
// Transaction types, microcode format and control program of the
// deduplicating message queue.
// ----------------------------------------------------------------------------
package dmf_pkg;

   localparam int COUNT_W = 5;
   localparam int MSG_W   = 40;
   localparam int STEP_W  = 4;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  msg_code;
      logic [15:0] low_param;
      logic [15:0] high_param;
   } dmf_req_type;

   typedef struct packed {
      logic               ok;
      logic [7:0]         out_code;
      logic [15:0]        out_low;
      logic [15:0]        out_high;
      logic [COUNT_W-1:0] count_after;
   } dmf_rsp_type;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LATCH,
      ACT_SCAN_INIT,
      ACT_SCAN_READ,
      ACT_APPEND,
      ACT_POP_READ,
      ACT_REPORT_PUSH,
      ACT_REPORT_POP
   } dmf_act_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_START,
      COND_POP,
      COND_FULL,
      COND_SCAN_DONE,
      COND_MATCH,
      COND_EMPTY
   } dmf_cond_type;

   typedef struct packed {
      dmf_act_type       act;
      dmf_cond_type      cond;
      logic [STEP_W-1:0] target;
   } dmf_uword_type;

   localparam logic [STEP_W-1:0] STEP_IDLE        = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DISPATCH    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_PUSH_INIT   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_SCAN_TEST   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_SCAN_READ   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_SCAN_CMP    = 4'd5;
   localparam logic [STEP_W-1:0] STEP_SCAN_LOOP   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_APPEND      = 4'd7;
   localparam logic [STEP_W-1:0] STEP_REPORT_PUSH = 4'd8;
   localparam logic [STEP_W-1:0] STEP_POP_TEST    = 4'd9;
   localparam logic [STEP_W-1:0] STEP_POP_READ    = 4'd10;
   localparam logic [STEP_W-1:0] STEP_REPORT_POP  = 4'd11;

   // condition true: jump to target, else fall through to the next step
   function automatic dmf_uword_type ucode_rom(input logic [STEP_W-1:0] step);
      dmf_uword_type w;
      unique case (step)
         STEP_IDLE:        w = '{ACT_LATCH,       COND_NO_START,  STEP_IDLE};
         STEP_DISPATCH:    w = '{ACT_NONE,        COND_POP,       STEP_POP_TEST};
         STEP_PUSH_INIT:   w = '{ACT_SCAN_INIT,   COND_FULL,      STEP_REPORT_PUSH};
         STEP_SCAN_TEST:   w = '{ACT_NONE,        COND_SCAN_DONE, STEP_APPEND};
         STEP_SCAN_READ:   w = '{ACT_SCAN_READ,   COND_NEXT,      STEP_IDLE};
         STEP_SCAN_CMP:    w = '{ACT_NONE,        COND_MATCH,     STEP_REPORT_PUSH};
         STEP_SCAN_LOOP:   w = '{ACT_NONE,        COND_ALWAYS,    STEP_SCAN_TEST};
         STEP_APPEND:      w = '{ACT_APPEND,      COND_NEXT,      STEP_IDLE};
         STEP_REPORT_PUSH: w = '{ACT_REPORT_PUSH, COND_ALWAYS,    STEP_IDLE};
         STEP_POP_TEST:    w = '{ACT_NONE,        COND_EMPTY,     STEP_REPORT_PUSH};
         STEP_POP_READ:    w = '{ACT_POP_READ,    COND_NEXT,      STEP_IDLE};
         STEP_REPORT_POP:  w = '{ACT_REPORT_POP,  COND_ALWAYS,    STEP_IDLE};
         default:          w = '{ACT_NONE,        COND_ALWAYS,    STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/dedup_message_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_message_fifo
// Message queue that rejects full pushes and duplicate messages, run by a
// small microcoded sequencer over a slot memory with one write and one read port.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; exactly one result
// follows on rsp_payload, marked by a one-cycle rsp_valid, and it cannot be held
// off. A push is appended after every stored message is checked, refused as a
// duplicate at the first stored message that matches, and refused without a
// scan when the queue is full. The duplicate scan reads one slot per pass
// through the test, read, compare and loop steps, through the one read port of
// the slot memory. The next transaction may start in the cycle the result is
// shown. No clearing pass runs after reset.
module dedup_message_fifo #(
   parameter int DEPTH = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire dmf_pkg::dmf_req_type req_payload,
   output logic                 rsp_valid,
   output dmf_pkg::dmf_rsp_type rsp_payload,
   input  wire                  psel,
   input  wire                  penable,
   input  wire                  pwrite,
   input  wire  [2:0]           paddr,
   input  wire  [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import dmf_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   localparam logic REG_CAPACITY   = 1'b0;
   localparam logic REG_EMPTY_CODE = 1'b1;

   logic [COUNT_W-1:0] capacity_ff;
   logic [7:0]         empty_code_ff;

   logic [STEP_W-1:0]  pc_ff;
   logic [STEP_W-1:0]  pc_in;
   dmf_req_type        req_ff;
   logic               ok_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] scan_cnt_ff;
   logic [IW-1:0]      head_ff;
   logic [IW-1:0]      tail_ff;
   logic [IW-1:0]      scan_ptr_ff;
   logic [MSG_W-1:0]   rd_ff;
   logic               rsp_valid_ff;
   dmf_rsp_type        rsp_ff;

   logic [MSG_W-1:0]   mem [DEPTH];

   dmf_uword_type      uw;
   logic               cond_true;
   logic [COUNT_W-1:0] limit;
   logic [MSG_W-1:0]   req_msg;
   logic [IW-1:0]      rd_addr;
   logic               csr_wr;

   function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
      return (p == LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   assign uw      = ucode_rom(pc_ff);
   assign busy    = (pc_ff != STEP_IDLE);
   assign req_msg = {req_ff.msg_code, req_ff.high_param, req_ff.low_param};
   assign limit   = (32'(capacity_ff) > DEPTH) ? COUNT_W'(DEPTH) : capacity_ff;
   assign rd_addr = (uw.act == ACT_POP_READ) ? head_ff : scan_ptr_ff;

   always_comb begin
      case (uw.cond)
         COND_NEXT:      cond_true = 1'b0;
         COND_ALWAYS:    cond_true = 1'b1;
         COND_NO_START:  cond_true = !start;
         COND_POP:       cond_true = (req_ff.req_type == REQ_POP);
         COND_FULL:      cond_true = (count_ff >= limit);
         COND_SCAN_DONE: cond_true = (scan_cnt_ff == count_ff);
         COND_MATCH:     cond_true = (rd_ff == req_msg);
         COND_EMPTY:     cond_true = (count_ff == '0);
         default:        cond_true = 1'b0;
      endcase
      pc_in = cond_true ? uw.target : pc_ff + 1'b1;
   end

   // sequencer and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= 1'b0;
         case (uw.act)
            ACT_LATCH: begin
               if (start) begin
                  req_ff <= req_payload;
                  ok_ff  <= 1'b0;
               end
            end
            ACT_SCAN_INIT: begin
               scan_ptr_ff <= head_ff;
               scan_cnt_ff <= '0;
            end
            ACT_SCAN_READ: begin
               scan_ptr_ff <= ptr_inc(scan_ptr_ff);
               scan_cnt_ff <= scan_cnt_ff + 1'b1;
            end
            ACT_APPEND: begin
               tail_ff  <= ptr_inc(tail_ff);
               count_ff <= count_ff + 1'b1;
               ok_ff    <= 1'b1;
            end
            ACT_POP_READ: begin
               head_ff  <= ptr_inc(head_ff);
               count_ff <= count_ff - 1'b1;
               ok_ff    <= 1'b1;
            end
            ACT_REPORT_PUSH: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= '{ok_ff, empty_code_ff, 16'd0, 16'd0, count_ff};
            end
            ACT_REPORT_POP: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= '{ok_ff, rd_ff[39:32], rd_ff[15:0], rd_ff[31:16], count_ff};
            end
            default: begin
            end
         endcase
      end
   end

   // slot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (uw.act == ACT_APPEND) begin
         mem[tail_ff] <= req_msg;
      end
      if (uw.act == ACT_SCAN_READ || uw.act == ACT_POP_READ) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // register port
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= 5'd16;
         empty_code_ff <= 8'd0;
      end else if (csr_wr) begin
         unique case (paddr[2])
            REG_CAPACITY:   capacity_ff   <= pwdata[COUNT_W-1:0];
            REG_EMPTY_CODE: empty_code_ff <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_CAPACITY:   prdata = {27'd0, capacity_ff};
         REG_EMPTY_CODE: prdata = {24'd0, empty_code_ff};
         default:        prdata = '0;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while sequencer busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("stored count beyond depth");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start the sequencer");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (uw.act == ACT_POP_READ) |-> (count_ff != '0))
      else $error("pop read with empty queue");

endmodule
`default_nettype wire

// ===== tb/dedup_message_fifo_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_message_fifo_tb
// Self-checking bench for the duplicate-rejecting message queue. Pushes and
// pops go in over the start/busy handshake, and an in-bench model of the
// queue predicts each response: ok flag, popped message or empty code, and
// the count after the step. Directed tests cover the empty pop, field
// extremes, duplicates, the full queue and the capacity corner settings.
// Random phases follow, each under its own capacity and empty code, with
// random idle gaps on the request side in every phase but one.
// ----------------------------------------------------------------------------
module dedup_message_fifo_tb;
   import dmf_pkg::*;

   localparam int QDEPTH         = 16;
   localparam int REG_CAPACITY   = 0;
   localparam int REG_EMPTY_CODE = 1;
   localparam int PHASE_ITEMS    = 125;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   dmf_req_type req_payload = '0;
   logic        rsp_valid;
   dmf_rsp_type rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   logic [39:0] held_msgs[$];
   logic [4:0]  cap_setting = 5'd16;
   logic [7:0]  empty_code_setting = 8'd0;
   dmf_rsp_type pending_rsps[$];
   int          fail_count = 0;

   dedup_message_fifo #(.DEPTH(QDEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic dmf_rsp_type apply_request(dmf_req_type r);
      dmf_rsp_type rsp;
      logic [39:0] msg;
      int          limit;
      bit          dup;
      rsp = '0;
      rsp.out_code = empty_code_setting;
      limit = (cap_setting > QDEPTH) ? QDEPTH : cap_setting;
      if (r.req_type == REQ_PUSH) begin
         msg = {r.msg_code, r.high_param, r.low_param};
         dup = 1'b0;
         foreach (held_msgs[i])
            if (held_msgs[i] == msg) dup = 1'b1;
         if (held_msgs.size() < limit && !dup) begin
            held_msgs.push_back(msg);
            rsp.ok = 1'b1;
         end
      end else if (held_msgs.size() > 0) begin
         msg = held_msgs.pop_front();
         rsp.ok       = 1'b1;
         rsp.out_code = msg[39:32];
         rsp.out_high = msg[31:16];
         rsp.out_low  = msg[15:0];
      end
      rsp.count_after = 5'(held_msgs.size());
      return rsp;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      dmf_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %0h", $time, rsp_payload);
            fail_count++;
         end else begin
            want = pending_rsps.pop_front();
            compare_field("ok", 32'(want.ok), 32'(rsp_payload.ok));
            compare_field("out_code", 32'(want.out_code), 32'(rsp_payload.out_code));
            compare_field("out_low", 32'(want.out_low), 32'(rsp_payload.out_low));
            compare_field("out_high", 32'(want.out_high), 32'(rsp_payload.out_high));
            compare_field("count_after", 32'(want.count_after),
                          32'(rsp_payload.count_after));
         end
      end
   end

   // leaves start high so back-to-back transactions need no gap
   task automatic send_msg(dmf_req_type r);
      @(negedge clock);
      start = 1'b1;
      req_payload = r;
      do @(posedge clock); while (busy);
      pending_rsps.push_back(apply_request(r));
   endtask

   task automatic quiet(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   task automatic drain();
      quiet(1);
      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(int idx, logic [31:0] value);
      logic [31:0] want;
      drain();
      if (idx == REG_CAPACITY) begin
         cap_setting = value[4:0];
         want = {27'd0, value[4:0]};
      end else begin
         empty_code_setting = value[7:0];
         want = {24'd0, value[7:0]};
      end
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = 3'(idx * 4);
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable = 1'b0;
      pwrite = 1'b0;
      pwdata = $urandom;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      compare_field("register readback", want, prdata);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   function automatic dmf_req_type mk_push(logic [7:0] code, logic [15:0] lo, logic [15:0] hi);
      dmf_req_type r;
      r.req_type   = REQ_PUSH;
      r.msg_code   = code;
      r.low_param  = lo;
      r.high_param = hi;
      return r;
   endfunction

   function automatic dmf_req_type mk_pop();
      dmf_req_type r;
      r = mk_push(8'($urandom), 16'($urandom), 16'($urandom));
      r.req_type = REQ_POP;
      return r;
   endfunction

   // small value pool so that duplicates come up often
   function automatic dmf_req_type rand_push();
      if ($urandom_range(0, 99) < 60)
         return mk_push(8'($urandom_range(0, 3)), $urandom_range(0, 1) ? 16'hffff : 16'h0000,
                        16'($urandom_range(0, 1)));
      return mk_push(8'($urandom), 16'($urandom), 16'($urandom));
   endfunction

   task automatic test_empty_pop();
      send_msg(mk_pop());
      write_reg(REG_EMPTY_CODE, 32'h0000_00a5);
      send_msg(mk_pop());
   endtask

   task automatic test_field_extremes();
      write_reg(REG_EMPTY_CODE, 32'hffff_ff3c);
      send_msg(mk_push(8'h00, 16'h0000, 16'h0000));
      send_msg(mk_push(8'hff, 16'hffff, 16'hffff));
      send_msg(mk_push(8'hff, 16'hffff, 16'hffff));
      send_msg(mk_push(8'hff, 16'hfffe, 16'hffff));
      send_msg(mk_push(8'h00, 16'h0000, 16'h0000));
      repeat (4) send_msg(mk_pop());
   endtask

   task automatic test_full_refusal();
      write_reg(REG_CAPACITY, 32'd2);
      send_msg(mk_push(8'h11, 16'h1234, 16'h5678));
      send_msg(mk_push(8'h22, 16'h9abc, 16'hdef0));
      send_msg(mk_push(8'h33, 16'h0001, 16'h8000));
      repeat (2) send_msg(mk_pop());
   endtask

   task automatic test_capacity_shrink();
      write_reg(REG_CAPACITY, 32'd16);
      send_msg(mk_push(8'h01, 16'h0101, 16'h1010));
      send_msg(mk_push(8'h02, 16'h0202, 16'h2020));
      send_msg(mk_push(8'h03, 16'h0303, 16'h3030));
      write_reg(REG_CAPACITY, 32'd1);
      send_msg(mk_push(8'h04, 16'h0404, 16'h4040));
      repeat (2) send_msg(mk_pop());
      send_msg(mk_push(8'h04, 16'h0404, 16'h4040));
      send_msg(mk_pop());
      send_msg(mk_push(8'h04, 16'h0404, 16'h4040));
      send_msg(mk_pop());
   endtask

   task automatic test_capacity_zero();
      write_reg(REG_CAPACITY, 32'hffff_ffe0);
      send_msg(mk_push(8'h55, 16'haaaa, 16'h5555));
      send_msg(mk_pop());
   endtask

   task automatic test_random_traffic();
      logic [4:0] caps[8];
      int         push_pct;
      bit         idle_on;
      caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd16, 5'd2, 5'($urandom_range(3, 15))};
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(REG_CAPACITY, ($urandom & 32'hffff_ffe0) | 32'(caps[ph]));
         write_reg(REG_EMPTY_CODE, (ph == 1) ? 32'hff : (ph == 4) ? 32'h0 : $urandom);
         push_pct = (ph % 2 == 0) ? 75 : $urandom_range(30, 65);
         idle_on = (ph != 5);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (idle_on && $urandom_range(0, 99) < 14) quiet($urandom_range(1, 60));
            if ($urandom_range(0, 99) < push_pct) send_msg(rand_push());
            else send_msg(mk_pop());
         end
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;
      test_empty_pop();
      test_field_extremes();
      test_full_refusal();
      test_capacity_shrink();
      test_capacity_zero();
      test_random_traffic();
      quiet(1);
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
